[hdl/positional_list_engine_assert.svh]
// assertion macros used by the checker file ple_checker
// expects clk and arst_n to be visible where a macro is used
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// same-cycle implication
`define PLE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("positional list engine: assertion failed");

// next-cycle implication
`define PLE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("positional list engine: assertion failed");

`endif

[hdl/ple_pkg.sv]
// shared constants, types and helpers for the positional list engine
// no dependencies
`timescale 1ns / 1ps

package ple_pkg;

	localparam int DEPTH      = 32;
	localparam int DATA_WIDTH = 32;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;

	localparam logic [2:0] F_APPEND   = 3'd0;
	localparam logic [2:0] F_INSERT   = 3'd1;
	localparam logic [2:0] F_DEL_TAIL = 3'd2;
	localparam logic [2:0] F_DEL_POS  = 3'd3;
	localparam logic [2:0] F_STREAM   = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef logic [DATA_WIDTH-1:0] cell_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic stream_load;
	} ple_cmd_t;

	typedef struct packed {
		logic stream_go;
		logic stream_last;
	} ple_sts_t;

	function automatic cell_t to_cell(input logic signed [31:0] v);
		return cell_t'(DATA_WIDTH'(v));
	endfunction

	function automatic logic signed [31:0] from_cell(input cell_t c);
		logic signed [DATA_WIDTH-1:0] s;
		s = signed'(c);
		return 32'(s);
	endfunction

endpackage

[hdl/positional_list_engine.sv]
// top level of the positional list engine: controller plus datapath
// depends on ple_pkg, ple_ctrl, ple_datapath
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------
//   in      | in_valid / in_ready  | func, pos, value
//   out     | out_valid / out_ready| status, count, data, last
//
// a request is accepted, then executed into the result register
// a stream is accepted, then the single result register is loaded from the cell
// array one cell a cycle while out_ready does not hold the output
// reset clears the element count; cell contents stay undefined until written
// out_ready low holds the execute or stream step; the next request is taken
// while the final result of the previous one still waits
`timescale 1ns / 1ps

module positional_list_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic [5:0]         pos,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [5:0]         count,
	output logic signed [31:0] data,
	output logic               last
);
	import ple_pkg::*;

	ple_cmd_t cmd;
	ple_sts_t sts;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ple_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.func   (func),
		.pos    (pos),
		.value  (value),
		.status (status),
		.count  (count),
		.data   (data),
		.last   (last)
	);

endmodule

[hdl/ple_ctrl.sv]
// controller state machine for the positional list engine
// depends on ple_pkg
`timescale 1ns / 1ps

module ple_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ple_pkg::ple_sts_t sts,
	output ple_pkg::ple_cmd_t cmd
);
	import ple_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_STREAM = 2'd2;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					if (sts.stream_go) begin
						cmd.stream_load = 1'b1;
						state_d = sts.stream_last ? S_IDLE : S_STREAM;
					end else begin
						cmd.exec = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			S_STREAM: begin
				if (out_free) begin
					cmd.stream_load = 1'b1;
					if (sts.stream_last)
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec || cmd.stream_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[hdl/ple_datapath.sv]
// shifting cell array, request registers and result register
// depends on ple_pkg
`timescale 1ns / 1ps

module ple_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  ple_pkg::ple_cmd_t  cmd,
	output ple_pkg::ple_sts_t  sts,
	input  logic [2:0]         func,
	input  logic [5:0]         pos,
	input  logic signed [31:0] value,
	output logic [1:0]         status,
	output logic [5:0]         count,
	output logic signed [31:0] data,
	output logic               last
);
	import ple_pkg::*;

	logic [2:0]       func_q;
	logic [5:0]       pos_q;
	cell_t            value_q;
	cell_t            cells_q [DEPTH];
	cell_t            cells_d [DEPTH];
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [IDX_W-1:0] idx_q;

	logic [1:0]        res_status_q;
	logic [5:0]        res_count_q;
	logic signed [31:0] res_data_q;
	logic              res_last_q;

	logic [CMP_W-1:0] pos_w, n_w, depth_w;
	logic [1:0]       st;

	assign pos_w   = CMP_W'(pos_q);
	assign n_w     = CMP_W'(cnt_q);
	assign depth_w = CMP_W'(DEPTH);

	assign sts.stream_go   = (func_q == F_STREAM) && (cnt_q != '0);
	assign sts.stream_last = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;

	// request status
	always_comb begin
		st = ST_OK;
		case (func_q)
			F_APPEND:
				if (n_w >= depth_w)
					st = ST_FULL;
			F_INSERT:
				if (pos_w == '0 || pos_w > n_w + CMP_W'(1))
					st = ST_BADPOS;
				else if (n_w >= depth_w)
					st = ST_FULL;
			F_DEL_TAIL:
				if (n_w == '0)
					st = ST_EMPTY;
			F_DEL_POS:
				if (n_w == '0)
					st = ST_EMPTY;
				else if (pos_w == '0 || pos_w > n_w)
					st = ST_BADPOS;
			default: st = ST_OK;
		endcase
	end

	// cell shifting and count update
	always_comb begin
		cells_d = cells_q;
		cnt_d   = cnt_q;
		if (cmd.exec && st == ST_OK) begin
			case (func_q)
				F_APPEND: begin
					for (int i = 0; i < DEPTH; i++)
						if (CMP_W'(i) == n_w)
							cells_d[i] = value_q;
					cnt_d = cnt_q + CNT_W'(1);
				end
				F_INSERT: begin
					if (pos_w == CMP_W'(1))
						cells_d[0] = value_q;
					for (int i = 1; i < DEPTH; i++) begin
						if (CMP_W'(i) + CMP_W'(1) == pos_w)
							cells_d[i] = value_q;
						else if (CMP_W'(i) >= pos_w)
							cells_d[i] = cells_q[i-1];
					end
					cnt_d = cnt_q + CNT_W'(1);
				end
				F_DEL_TAIL: cnt_d = cnt_q - CNT_W'(1);
				F_DEL_POS: begin
					for (int i = 0; i < DEPTH - 1; i++)
						if (CMP_W'(i) + CMP_W'(1) >= pos_w)
							cells_d[i] = cells_q[i+1];
					cnt_d = cnt_q - CNT_W'(1);
				end
				default: cnt_d = cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cells_q <= cells_d;
		if (cmd.latch) begin
			func_q  <= func;
			pos_q   <= pos;
			value_q <= to_cell(value);
		end
		if (cmd.exec) begin
			res_status_q <= st;
			res_count_q  <= 6'(cnt_d);
			res_data_q   <= '0;
			res_last_q   <= 1'b1;
		end else if (cmd.stream_load) begin
			res_status_q <= ST_OK;
			res_count_q  <= 6'(cnt_q);
			res_data_q   <= from_cell(cells_q[idx_q]);
			res_last_q   <= sts.stream_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			cnt_q <= cnt_d;
			if (cmd.latch)
				idx_q <= '0;
			else if (cmd.stream_load)
				idx_q <= idx_q + IDX_W'(1);
		end
	end

	assign status = res_status_q;
	assign count  = res_count_q;
	assign data   = res_data_q;
	assign last   = res_last_q;

endmodule

[hdl/ple_checker.sv]
// port-level checks for the positional list engine, bound to the top level
// depends on ple_pkg and positional_list_engine_assert.svh
`timescale 1ns / 1ps
`include "positional_list_engine_assert.svh"

module ple_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic [5:0]         count,
	input logic signed [31:0] data,
	input logic               last
);
	import ple_pkg::*;

	`PLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`PLE_ASSERT_NOW(a_count_range, out_valid, count <= 6'(DEPTH))
	`PLE_ASSERT_NOW(a_error_final, out_valid && status != ST_OK, last && data == '0)
	`PLE_ASSERT_NOW(a_data_ok, out_valid && data != '0, status == ST_OK)

endmodule

bind positional_list_engine ple_checker u_ple_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.count     (count),
	.data      (data),
	.last      (last)
);

[dv/ple_list_checker.sv]
// result checker for the positional list engine: predicts the list and compares every result
// depends on ple_pkg; watches the request and result channels of the block
`timescale 1ns / 1ps

module ple_list_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         func,
	input  logic [5:0]         pos,
	input  logic signed [31:0] value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         status,
	input  logic [5:0]         count,
	input  logic signed [31:0] data,
	input  logic               last,
	output int                 mismatches,
	output int                 results_owed,
	output int                 list_len,
	output int                 results_checked,
	output int                 error_results
);
	import ple_pkg::*;

	typedef struct packed {
		logic [1:0]         status;
		logic [5:0]         count;
		logic signed [31:0] data;
		logic               last;
	} list_result_t;

	list_result_t owed_q[$];
	logic signed [DATA_WIDTH-1:0] cells [DEPTH];
	int unsigned held;
	int n_bad;
	int n_checked;
	int n_err;

	task automatic owe_result(input logic [1:0] st, input logic signed [31:0] d, input logic lst);
		list_result_t r;
		r.status = st;
		r.count  = 6'(held);
		r.data   = d;
		r.last   = lst;
		owed_q.push_back(r);
	endtask

	task automatic apply_request(input logic [2:0] f, input logic [5:0] p,
			input logic signed [31:0] v);
		logic [1:0] st;
		int unsigned k;
		st = ST_OK;
		case (f)
			F_APPEND: begin
				if (held >= DEPTH) begin
					st = ST_FULL;
				end else begin
					cells[held] = DATA_WIDTH'(v);
					held++;
				end
			end
			F_INSERT: begin
				if (p == 0 || p > held + 1) begin
					st = ST_BADPOS;
				end else if (held >= DEPTH) begin
					st = ST_FULL;
				end else begin
					for (k = held; k >= p; k--)
						cells[k] = cells[k - 1];
					cells[p - 1] = DATA_WIDTH'(v);
					held++;
				end
			end
			F_DEL_TAIL: begin
				if (held == 0)
					st = ST_EMPTY;
				else
					held--;
			end
			F_DEL_POS: begin
				if (held == 0) begin
					st = ST_EMPTY;
				end else if (p == 0 || p > held) begin
					st = ST_BADPOS;
				end else begin
					for (k = p - 1; k + 1 < held; k++)
						cells[k] = cells[k + 1];
					held--;
				end
			end
			F_STREAM: begin
				if (held == 0) begin
					owe_result(ST_OK, '0, 1'b1);
				end else begin
					for (k = 0; k < held; k++)
						owe_result(ST_OK, 32'(cells[k]), k + 1 == held);
				end
				return;
			end
			default: ;
		endcase
		owe_result(st, '0, 1'b1);
	endtask

	task automatic check_result();
		list_result_t want;
		n_checked++;
		if (status != ST_OK)
			n_err++;
		if (owed_q.size() == 0) begin
			n_bad++;
			$display("%0t: unexpected result status %0d count %0d data %0d last %0d",
				$time, status, count, data, last);
		end else begin
			want = owed_q.pop_front();
			if (status !== want.status || count !== want.count ||
					data !== want.data || last !== want.last) begin
				n_bad++;
				$display({"%0t: expected status %0d count %0d data %0d last %0d,",
					" got status %0d count %0d data %0d last %0d"}, $time,
					want.status, want.count, want.data, want.last,
					status, count, data, last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q.delete();
			held = 0;
			n_bad = 0;
			n_checked = 0;
			n_err = 0;
			mismatches <= 0;
			results_owed <= 0;
			list_len <= 0;
			results_checked <= 0;
			error_results <= 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				apply_request(func, pos, value);
			mismatches <= n_bad;
			results_owed <= owed_q.size();
			list_len <= held;
			results_checked <= n_checked;
			error_results <= n_err;
		end
	end

endmodule

[dv/tb_positional_list_engine.sv]
// testbench top for the positional list engine: clock, reset, request and result traffic
// depends on ple_pkg, positional_list_engine and ple_list_checker
`timescale 1ns / 1ps

module tb_positional_list_engine;
	import ple_pkg::*;

	localparam int TOTAL_REQUESTS = 330;
	localparam int HOLD_CYCLES    = 300;
	localparam int IDLE_LIMIT     = 2000;
	localparam int SETTLE_CYCLES  = 20;

	localparam logic [2:0] F_SPARE_FIRST = 3'd5;
	localparam logic [2:0] F_SPARE_LAST  = 3'd7;

	localparam int EP_FILL  = 0;
	localparam int EP_DRAIN = 1;
	localparam int EP_MIX   = 2;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         func;
	logic [5:0]         pos;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [5:0]         count;
	logic signed [31:0] data;
	logic               last;

	int mismatches;
	int results_owed;
	int list_len;
	int results_checked;
	int error_results;

	int requests_sent;
	int streams_sent;
	int hold_reqs;
	bit sender_steady;

	positional_list_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.pos       (pos),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.count     (count),
		.data      (data),
		.last      (last)
	);

	ple_list_checker u_list_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.pos             (pos),
		.value           (value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.count           (count),
		.data            (data),
		.last            (last),
		.mismatches      (mismatches),
		.results_owed    (results_owed),
		.list_len        (list_len),
		.results_checked (results_checked),
		.error_results   (error_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic int sender_gap();
		if (sender_steady || $urandom_range(0, 2) != 0)
			return 0;
		return idle_len();
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// mostly a legal position, now and then anything the field holds
	function automatic logic [5:0] pick_pos(input int top_ok);
		if ($urandom_range(0, 7) == 0)
			return 6'($urandom_range(0, 63));
		return 6'($urandom_range(1, (top_ok < 1) ? 1 : top_ok));
	endfunction

	task automatic issue(input logic [2:0] f, input logic [5:0] p, input logic signed [31:0] v);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		pos <= p;
		value <= v;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
		if (f == F_STREAM)
			streams_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	// grow_pct steers the mix between growing and shrinking the list
	task automatic random_request(input int grow_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			issue(3'($urandom_range(F_SPARE_FIRST, F_SPARE_LAST)), 6'($urandom), $urandom);
		else if (r < 12)
			issue(F_STREAM, 6'($urandom), $urandom);
		else if (r < 12 + grow_pct) begin
			if ($urandom_range(0, 1))
				issue(F_APPEND, 6'($urandom), pick_value());
			else
				issue(F_INSERT, pick_pos(list_len + 1), pick_value());
		end else begin
			if ($urandom_range(0, 2) == 0)
				issue(F_DEL_TAIL, 6'($urandom), $urandom);
			else
				issue(F_DEL_POS, pick_pos(list_len), $urandom);
		end
	endtask

	task automatic run_episode(input int kind);
		int extra;
		extra = $urandom_range(1, 3);
		case (kind)
			EP_FILL: begin
				while (list_len < DEPTH)
					random_request(80);
				issue(F_INSERT, 6'(DEPTH + 1), pick_value());
				issue(F_INSERT, 6'(DEPTH + 2), pick_value());
				repeat (extra) random_request(88);
			end
			EP_DRAIN: begin
				while (list_len > 0)
					random_request(10);
				repeat (extra) random_request(0);
			end
			default: begin
				repeat ($urandom_range(8, 20)) random_request(45);
			end
		endcase
	endtask

	initial begin : receiver
		int holds_done;
		holds_done = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_reqs != holds_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(20, 120)) @(posedge clk);
				else
					repeat ($urandom_range(1, 12)) @(posedge clk);
				out_ready <= 1'b0;
				repeat (idle_len()) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		int episode;
		requests_sent = 0;
		streams_sent = 0;
		hold_reqs = 0;
		sender_steady = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= F_APPEND;
		pos <= '0;
		value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corner cases
		issue(F_STREAM, 6'd0, 32'sd0);
		issue(F_DEL_TAIL, 6'd1, 32'sd0);
		issue(F_DEL_POS, 6'd0, 32'sd0);
		issue(F_INSERT, 6'd0, 32'sd5);
		issue(F_INSERT, 6'd2, 32'sd5);
		// build up by prepend, append and middle insert
		issue(F_INSERT, 6'd1, 32'sh7fffffff);
		issue(F_APPEND, 6'd63, 32'sh80000000);
		issue(F_INSERT, 6'd1, -32'sd1);
		issue(F_INSERT, 6'd4, 32'sd0);
		issue(F_INSERT, 6'd2, 32'sh55555555);
		issue(F_INSERT, 6'd63, 32'shaaaaaaaa);
		issue(F_STREAM, 6'd63, 32'sd0);
		// deletes at the ends, the middle and outside the list
		issue(F_DEL_POS, 6'd0, 32'sd0);
		issue(F_DEL_POS, 6'd6, 32'sd0);
		issue(F_DEL_POS, 6'd5, 32'sd0);
		issue(F_DEL_POS, 6'd1, 32'sd0);
		issue(F_DEL_POS, 6'd2, 32'sd0);
		for (int f = F_SPARE_FIRST; f <= F_SPARE_LAST; f++)
			issue(3'(f), 6'd63, 32'shaaaaaaaa);
		issue(F_STREAM, 6'd0, 32'sd0);
		issue(F_DEL_TAIL, 6'd0, 32'sd0);
		issue(F_DEL_POS, 6'd1, 32'sd0);
		issue(F_STREAM, 6'd0, 32'sd0);
		wait_drained();

		// long output hold while the list fills
		hold_reqs++;
		run_episode(EP_FILL);
		wait_drained();

		episode = 0;
		while (requests_sent < TOTAL_REQUESTS) begin
			sender_steady = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 2))
				0: run_episode(EP_FILL);
				1: run_episode(EP_DRAIN);
				default: run_episode(EP_MIX);
			endcase
			episode++;
			if (episode % 4 == 0)
				wait_drained();
		end
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d requests (%0d list streams) over %0d random episodes,",
			requests_sent, streams_sent, episode);
		$display("full and empty lists, a long output hold; %0d results checked, %0d errors",
			results_checked, error_results);
		if (mismatches == 0 && results_owed == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/ple_pkg.sv
hdl/ple_ctrl.sv
hdl/ple_datapath.sv
hdl/positional_list_engine.sv
hdl/ple_checker.sv
dv/ple_list_checker.sv
dv/tb_positional_list_engine.sv
